### sv/qph_pkg.sv
package qph_pkg;

  localparam int KEY_W      = 64;
  localparam int LEN_W      = 4;
  localparam int WORD_W     = 64;
  localparam int SLOT_IDX_W = 6;

  // s_tdata: key_bytes, key_length, phone_in, address_in, zero pad to 200 bits
  localparam int IN_DATA_W  = 200;
  // m_tdata: phone_out, address_out, slot_index, zero pad to 136 bits
  localparam int OUT_DATA_W = 136;

  localparam logic [LEN_W-1:0] KEY_BYTES_MAX = 4'd8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [LEN_W-1:0]  key_length;
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] phone;
    logic [WORD_W-1:0] address;
  } slot_t;

endpackage

### sv/qph_ram.sv
module qph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/qph_hash.sv
module qph_hash #(
  parameter int TABLE_ENTRIES = 61,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [qph_pkg::KEY_W-1:0] key,
  input  logic [qph_pkg::LEN_W-1:0] key_length,
  output logic                      done,
  output logic [IDX_W-1:0]          home
);

  import qph_pkg::*;

  // room for 31*h + byte and for the modulus shifted up by seven
  localparam int RW = IDX_W + 8;

  logic             run;
  logic [LEN_W-1:0] cnt;
  logic [KEY_W-1:0] key_sh;
  logic [IDX_W-1:0] h;
  logic [RW-1:0]    t;
  logic [RW-1:0]    lim;

  // h*31 + byte, then restoring reduction: quotient stays below 128
  always_comb begin
    t = ({8'b0, h} << 5) - {8'b0, h} + RW'(key_sh[KEY_W-1 -: 8]);
    lim = '0;
    for (int k = 7; k >= 0; k--) begin
      lim = RW'(TABLE_ENTRIES) << k;
      if (t >= lim) begin
        t = t - lim;
      end
    end
  end

  assign done = run && (cnt == '0);
  assign home = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run    <= 1'b1;
      cnt    <= key_length;
      key_sh <= key;
      h      <= '0;
    end else if (run) begin
      if (cnt == '0) begin
        run <= 1'b0;
      end else begin
        h      <= t[IDX_W-1:0];
        key_sh <= {key_sh[KEY_W-9:0], 8'h00};
        cnt    <= cnt - 1'b1;
      end
    end
  end

endmodule

### sv/quadratic_probe_hash_table.sv
// Open-addressed key/value table with quadratic probing.
// Input channel s_*: one request per transfer. s_tuser selects insert or
// search; s_tdata carries the key (first byte on top, up to 8 bytes), its
// length and two payload words stored on insert.
// Output channel m_*: one response per request, in order. m_tuser is the
// status (inserted, found, not found, table full); m_tdata carries the found
// payload words (zero otherwise) and the slot used or found (zero otherwise).
// Timing: the home slot is hashed one key byte per cycle (key_length after
// saturation to 8), then each probe is one read of the slot memory per cycle.
// s_tready rises with m_tvalid, so a new request is accepted only once the
// response to the last one is loaded; one request is in work at a time, with up
// to TABLE_ENTRIES probes.
// The response sits in an output register: the next request is accepted
// while it waits, and a stalled m_tready holds only the finish of that next
// request.
// Reset starts a clearing pass over all TABLE_ENTRIES slots that marks every slot
// empty; s_tready stays low until it ends.
module quadratic_probe_hash_table #(
  parameter int TABLE_ENTRIES = 61
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // key_bytes[63:0], key_length[67:64], phone_in[131:68], address_in[195:132]
  input  logic [qph_pkg::IN_DATA_W-1:0]  s_tdata,
  // opcode[0]
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // phone_out[63:0], address_out[127:64], slot_index[133:128]
  output logic [qph_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]                     m_tuser
);

  import qph_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] D_INIT   = IDX_W'(1);
  localparam logic [IDX_W-1:0] O_INIT   = IDX_W'(3 % TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] TWO      = IDX_W'(2);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_CHECK,
    S_RESP
  } state_t;

  state_t            state;
  opcode_t           op;
  logic [KEY_W-1:0]  key;
  logic [LEN_W-1:0]  len;
  logic [WORD_W-1:0] phone;
  logic [WORD_W-1:0] address;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  probe;
  logic [IDX_W-1:0]  jump;
  logic [IDX_W-1:0]  odd;
  status_t           res_status;
  logic [WORD_W-1:0] res_phone;
  logic [WORD_W-1:0] res_address;
  logic [SLOT_IDX_W-1:0] res_slot;

  logic [LEN_W-1:0]  in_len;
  logic [KEY_W-1:0]  in_key;
  logic              hash_done;
  logic [IDX_W-1:0]  hash_home;
  logic [IDX_W-1:0]  idx_adv;
  logic [IDX_W+SLOT_IDX_W-1:0] idx_wide;
  logic              hit;
  logic              resp_load;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  slot_t             ram_wdata;
  slot_t             rd;
  logic [$bits(slot_t)-1:0] ram_rdata;

  function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(TABLE_ENTRIES)) begin
      s = s - (IDX_W+1)'(TABLE_ENTRIES);
    end
    return s[IDX_W-1:0];
  endfunction

  // saturate the length, zero the bytes past it
  always_comb begin
    in_len = (s_tdata[67:64] > KEY_BYTES_MAX) ? KEY_BYTES_MAX : s_tdata[67:64];
    in_key = s_tdata[63:0];
    for (int i = 0; i < 8; i++) begin
      if (LEN_W'(i) >= in_len) begin
        in_key[KEY_W-1-8*i -: 8] = 8'h00;
      end
    end
  end

  qph_hash #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_hash (
    .clk        (clk),
    .rst        (rst),
    .start      (s_tvalid && s_tready),
    .key        (in_key),
    .key_length (in_len),
    .done       (hash_done),
    .home       (hash_home)
  );

  assign rd       = ram_rdata;
  assign hit      = (op == OP_SEARCH) && (rd.key_length == len) && (rd.key == key);
  assign idx_adv  = mod_add(idx, jump);
  assign idx_wide = {{SLOT_IDX_W{1'b0}}, idx};

  // read the home slot as the hash finishes, then the next probe each cycle
  assign ram_raddr = (state == S_CHECK) ? idx_adv : hash_home;
  assign ram_we    = (state == S_CLEAR) ||
                     ((state == S_CHECK) && !rd.valid && (op == OP_INSERT));

  always_comb begin
    ram_wdata            = '0;
    if (state == S_CHECK) begin
      ram_wdata.valid      = 1'b1;
      ram_wdata.key_length = len;
      ram_wdata.key        = key;
      ram_wdata.phone      = phone;
      ram_wdata.address    = address;
    end
  end

  qph_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready  = (state == S_IDLE);
  assign resp_load = (state == S_RESP) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (resp_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= opcode_t'(s_tuser[0]);
            key     <= in_key;
            len     <= in_len;
            phone   <= s_tdata[131:68];
            address <= s_tdata[195:132];
            state   <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            idx   <= hash_home;
            probe <= '0;
            jump  <= D_INIT;
            odd   <= O_INIT;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          priority if (!rd.valid) begin
            // empty slot ends the walk; insert claims it
            res_status  <= (op == OP_INSERT) ? ST_INSERTED : ST_NOT_FOUND;
            res_phone   <= '0;
            res_address <= '0;
            res_slot    <= (op == OP_INSERT) ? idx_wide[SLOT_IDX_W-1:0] : '0;
            state       <= S_RESP;
          end else if (hit) begin
            res_status  <= ST_FOUND;
            res_phone   <= rd.phone;
            res_address <= rd.address;
            res_slot    <= idx_wide[SLOT_IDX_W-1:0];
            state       <= S_RESP;
          end else if (probe == LAST_IDX) begin
            res_status  <= (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
            res_phone   <= '0;
            res_address <= '0;
            res_slot    <= '0;
            state       <= S_RESP;
          end else begin
            // advance by the next square: jump = k^2, odd = 2k+1, all mod N
            idx   <= idx_adv;
            jump  <= mod_add(jump, odd);
            odd   <= mod_add(odd, TWO);
            probe <= probe + 1'b1;
          end
        end
        S_RESP: begin
          if (resp_load) begin
            m_tuser  <= res_status;
            m_tdata  <= {2'b00, res_slot, res_address, res_phone};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ram_we_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_CHECK))
    else $error("slot memory written outside clear or check");

  a_insert_resp: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && ram_we) |=> (state == S_RESP && res_status == ST_INSERTED))
    else $error("slot write without an inserted response");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ({1'b0, idx} < (IDX_W+1)'(TABLE_ENTRIES)))
    else $error("probe index out of range");

  a_home_range: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> ({1'b0, hash_home} < (IDX_W+1)'(TABLE_ENTRIES)))
    else $error("home slot out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_FOUND) |-> (m_tdata[127:0] == '0))
    else $error("payload words not zero on a response other than found");

endmodule

### tb/qph_checker.sv
module qph_checker #(
  parameter int TABLE_ENTRIES = 61
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // key_bytes[63:0], key_length[67:64], phone_in[131:68], address_in[195:132]
  input  logic [qph_pkg::IN_DATA_W-1:0]  s_tdata,
  // opcode[0]
  input  logic [0:0]                     s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // phone_out[63:0], address_out[127:64], slot_index[133:128]
  input  logic [qph_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  input  logic [1:0]                     m_tuser,
  output int                             mismatches,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import qph_pkg::*;

  typedef struct packed {
    status_t                 status;
    logic [WORD_W-1:0]       phone;
    logic [WORD_W-1:0]       address;
    logic [SLOT_IDX_W-1:0]   slot;
  } response_t;

  slot_t     slots [TABLE_ENTRIES];
  response_t resp_due [$];
  int        err_total = 0;

  function automatic int unsigned home_of(logic [KEY_W-1:0] key, int unsigned len);
    int unsigned h;
    h = 0;
    for (int unsigned i = 0; i < len; i++) begin
      h = (h * 31 + key[63 - 8 * i -: 8]) % TABLE_ENTRIES;
    end
    return h;
  endfunction

  // Walk the probe sequence for one request and update the table copy.
  function automatic response_t serve_request(opcode_t op, logic [KEY_W-1:0] key_in,
                                              logic [LEN_W-1:0] len_in,
                                              logic [WORD_W-1:0] ph,
                                              logic [WORD_W-1:0] ad);
    int unsigned      len;
    int unsigned      idx;
    logic [KEY_W-1:0] mask;
    logic [KEY_W-1:0] key;
    response_t        r;
    len  = 32'((len_in > KEY_BYTES_MAX) ? KEY_BYTES_MAX : len_in);
    mask = (len == 0) ? '0 : (~64'd0 << (64 - 8 * len));
    key  = key_in & mask;
    idx  = home_of(key, len);
    r    = '0;
    if (op == OP_SEARCH) begin
      r.status = ST_NOT_FOUND;
    end else begin
      r.status = ST_FULL;
    end
    for (int unsigned p = 0; p < TABLE_ENTRIES; p++) begin
      if (!slots[idx].valid) begin
        if (op == OP_INSERT) begin
          slots[idx].valid      = 1'b1;
          slots[idx].key        = key;
          slots[idx].key_length = len[LEN_W-1:0];
          slots[idx].phone      = ph;
          slots[idx].address    = ad;
          r.status = ST_INSERTED;
          r.slot   = idx[SLOT_IDX_W-1:0];
        end
        break;
      end
      if (op == OP_SEARCH && slots[idx].key_length == len[LEN_W-1:0] &&
          slots[idx].key == key) begin
        r.status  = ST_FOUND;
        r.phone   = slots[idx].phone;
        r.address = slots[idx].address;
        r.slot    = idx[SLOT_IDX_W-1:0];
        break;
      end
      idx = (idx + (p + 1) * (p + 1)) % TABLE_ENTRIES;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      foreach (slots[i]) slots[i].valid = 1'b0;
      resp_due.delete();
    end else begin
      // Compare first: a response never leaves on the edge of its own request.
      if (m_tvalid && m_tready) begin
        if (resp_due.size() == 0) begin
          $error("unexpected response: status %0d slot_index %0d", m_tuser, m_tdata[133:128]);
          err_total++;
        end else begin
          want = resp_due.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            err_total++;
          end
          if (m_tdata[63:0] !== want.phone) begin
            $error("phone_out: expected %h, got %h", want.phone, m_tdata[63:0]);
            err_total++;
          end
          if (m_tdata[127:64] !== want.address) begin
            $error("address_out: expected %h, got %h", want.address, m_tdata[127:64]);
            err_total++;
          end
          if (m_tdata[133:128] !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, m_tdata[133:128]);
            err_total++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        resp_due.push_back(serve_request(opcode_t'(s_tuser[0]), s_tdata[63:0],
                                         s_tdata[67:64], s_tdata[131:68],
                                         s_tdata[195:132]));
      end
    end
    mismatches  <= err_total;
    outstanding <= resp_due.size();
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qph_pkg::*;

  localparam int TABLE_ENTRIES  = 61;
  localparam int PHASE_ITEMS    = 325;
  localparam int QUIET_LIMIT    = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 100;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } key_ref_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [0:0]            s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;

  int mismatches;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int hold_left      = 0;
  bit long_hold      = 1'b0;

  key_ref_t known_keys [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  quadratic_probe_hash_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  qph_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Response side: random stalls, or a long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[quadratic_probe_hash_table] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(opcode_t op, logic [KEY_W-1:0] key, logic [LEN_W-1:0] len,
                              logic [WORD_W-1:0] ph, logic [WORD_W-1:0] ad);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {4'b0, ad, ph, len, key};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int               pick;
    int unsigned      sat;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] mask;
    logic [LEN_W-1:0] len;
    key_ref_t         ref_key;

    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Empty key, zero payload; search it with garbage bytes that mask away.
    send_request(OP_INSERT, 64'd0, 4'd0, 64'd0, 64'd0);
    send_request(OP_SEARCH, ~64'd0, 4'd0, 64'd0, 64'd0);
    // All-ones key and payload, then the long-length and short-length variants.
    send_request(OP_INSERT, ~64'd0, 4'd8, ~64'd0, ~64'd0);
    send_request(OP_SEARCH, ~64'd0, 4'd15, 64'd0, 64'd0);
    send_request(OP_SEARCH, ~64'd0, 4'd7, ~64'd0, ~64'd0);
    // Unused low bytes differ between insert and search.
    send_request(OP_INSERT, 64'h41DE_ADBE_EF01_2345, 4'd1, 64'h1111, 64'h2222);
    send_request(OP_SEARCH, 64'h41FF_FFFF_FFFF_FFFF, 4'd1, 64'd0, 64'd0);
    // Duplicate insert lands further along; search returns the first.
    send_request(OP_INSERT, 64'h4100_0000_0000_0000, 4'd1, 64'h3333, 64'h4444);
    send_request(OP_SEARCH, 64'h4100_0000_0000_0000, 4'd1, 64'd0, 64'd0);
    // Three single-byte keys with the same home slot.
    send_request(OP_INSERT, 64'h0100_0000_0000_0000, 4'd1, 64'h5555, 64'h6666);
    send_request(OP_INSERT, 64'h3E00_0000_0000_0000, 4'd1, 64'h7777, 64'h8888);
    send_request(OP_INSERT, 64'h7B00_0000_0000_0000, 4'd1, 64'h9999, 64'hAAAA);
    send_request(OP_SEARCH, 64'h7B00_0000_0000_0000, 4'd1, 64'd0, 64'd0);
    send_request(OP_SEARCH, 64'h3E00_0000_0000_0000, 4'd1, 64'd0, 64'd0);
    send_request(OP_SEARCH, 64'h0100_0000_0000_0000, 4'd1, 64'd0, 64'd0);
    send_request(OP_SEARCH, 64'h3E00_0000_0000_0000, 4'd2, 64'd0, 64'd0);
    // Saturating length on insert, exact length on search.
    send_request(OP_INSERT, 64'h0123_4567_89AB_CDEF, 4'd12, 64'hBBBB, 64'hCCCC);
    send_request(OP_SEARCH, 64'h0123_4567_89AB_CDEF, 4'd8, 64'd0, 64'd0);
    send_request(OP_SEARCH, 64'h5A5A_5A5A_0000_0000, 4'd4, 64'd0, 64'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // Fill the block while the response side is held off.
          long_hold = 1'b1;
        end
        1: begin
          send_idle_pct  = 54;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 54;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          if (known_keys.size() > 0 && $urandom_range(4) == 0) begin
            ref_key = known_keys[$urandom_range(known_keys.size() - 1)];
          end else begin
            ref_key.key = {$urandom, $urandom};
            ref_key.len = LEN_W'($urandom_range(15));
            known_keys.push_back(ref_key);
          end
          send_request(OP_INSERT, ref_key.key, ref_key.len, {$urandom, $urandom},
                       {$urandom, $urandom});
        end else if (pick < 70 && known_keys.size() > 0) begin
          ref_key = known_keys[$urandom_range(known_keys.size() - 1)];
          key = ref_key.key;
          len = ref_key.len;
          if ($urandom_range(2) == 0) begin
            // Same key as stored: scramble the masked bytes, vary a saturated length.
            sat  = 32'((len > KEY_BYTES_MAX) ? KEY_BYTES_MAX : len);
            mask = (sat == 0) ? '0 : (~64'd0 << (64 - 8 * sat));
            key  = (key & mask) | ({$urandom, $urandom} & ~mask);
            if (sat == KEY_BYTES_MAX) len = LEN_W'($urandom_range(15, 8));
          end
          send_request(OP_SEARCH, key, len, {$urandom, $urandom}, {$urandom, $urandom});
        end else begin
          send_request(OP_SEARCH, {$urandom, $urandom}, LEN_W'($urandom_range(15)),
                       {$urandom, $urandom}, {$urandom, $urandom});
        end
      end
    end
    s_tvalid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[quadratic_probe_hash_table] OK");
    end else begin
      $display("[quadratic_probe_hash_table] ERROR");
    end
    $finish;
  end

endmodule
